// ----- src/rle_ovl_pkg.sv -----
// Shared types and constants for the overlay run splitter.
package rle_ovl_pkg;

    localparam int PALETTE_ENTRIES = 16;

    // Configuration register indexes
    localparam logic [2:0] REG_OVERLAY_WIDTH = 3'd0;
    localparam logic [2:0] REG_WIN_LEFT      = 3'd1;
    localparam logic [2:0] REG_WIN_RIGHT     = 3'd2;
    localparam logic [2:0] REG_WIN_TOP       = 3'd3;
    localparam logic [2:0] REG_WIN_BOTTOM    = 3'd4;
    localparam logic [2:0] REG_ORIGIN_X      = 3'd5;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd6;
    localparam logic [2:0] REG_OPAQUE_MASKS  = 3'd7;

    // Register reset values
    localparam logic [10:0] OVERLAY_WIDTH_RST = 11'd720;
    localparam logic [9:0]  WIN_LEFT_RST      = 10'd0;
    localparam logic [9:0]  WIN_RIGHT_RST     = 10'd1023;
    localparam logic [9:0]  WIN_TOP_RST       = 10'd0;
    localparam logic [9:0]  WIN_BOTTOM_RST    = 10'd1023;
    localparam logic [9:0]  ORIGIN_X_RST      = 10'd0;
    localparam logic [9:0]  ORIGIN_Y_RST      = 10'd0;
    localparam logic [31:0] OPAQUE_MASKS_RST  = 32'h0000_0000;

    localparam logic [10:0] MIN_LINE_WIDTH = 11'd64;

    typedef struct packed {
        logic [10:0] overlay_width;
        logic [9:0]  win_left;
        logic [9:0]  win_right;
        logic [9:0]  win_top;
        logic [9:0]  win_bottom;
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
        logic [31:0] opaque_masks;
    } t_cfg;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [10:0] width;
        logic [3:0]  color;
        logic        clip;
    } t_seg;

    typedef struct packed {
        logic load;
        logic start;
        logic limit;
        logic step;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic len_zero;
        logic rem_zero;
        logic seg_vis;
        logic pend_valid;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- src/rle_ovl_cfg.sv -----
// Configuration registers and effective line width.
module rle_ovl_cfg
    import rle_ovl_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [2:0]                            i_cfg_index,
    input  logic [31:0]                           i_cfg_data,
    output t_cfg                                  o_cfg,
    output logic [$clog2(MAX_LINE_WIDTH+1)-1:0]   o_line_width
);
    localparam int LW_W = $clog2(MAX_LINE_WIDTH + 1);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OVERLAY_WIDTH: n_cfg.overlay_width = i_cfg_data[10:0];
                REG_WIN_LEFT:      n_cfg.win_left      = i_cfg_data[9:0];
                REG_WIN_RIGHT:     n_cfg.win_right     = i_cfg_data[9:0];
                REG_WIN_TOP:       n_cfg.win_top       = i_cfg_data[9:0];
                REG_WIN_BOTTOM:    n_cfg.win_bottom    = i_cfg_data[9:0];
                REG_ORIGIN_X:      n_cfg.origin_x      = i_cfg_data[9:0];
                REG_ORIGIN_Y:      n_cfg.origin_y      = i_cfg_data[9:0];
                REG_OPAQUE_MASKS:  n_cfg.opaque_masks  = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overlay_width <= OVERLAY_WIDTH_RST;
            r_cfg.win_left      <= WIN_LEFT_RST;
            r_cfg.win_right     <= WIN_RIGHT_RST;
            r_cfg.win_top       <= WIN_TOP_RST;
            r_cfg.win_bottom    <= WIN_BOTTOM_RST;
            r_cfg.origin_x      <= ORIGIN_X_RST;
            r_cfg.origin_y      <= ORIGIN_Y_RST;
            r_cfg.opaque_masks  <= OPAQUE_MASKS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Saturate the line width to the supported range
    always_comb begin
        if (r_cfg.overlay_width < MIN_LINE_WIDTH) begin
            o_line_width = LW_W'(MIN_LINE_WIDTH);
        end else if (32'(r_cfg.overlay_width) > MAX_LINE_WIDTH) begin
            o_line_width = LW_W'(MAX_LINE_WIDTH);
        end else begin
            o_line_width = LW_W'(r_cfg.overlay_width);
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/rle_ovl_ctrl.sv -----
// Controller sequencing the split of one run into segments.
module rle_ovl_ctrl
    import rle_ovl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_run_valid,
    output logic    o_run_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_LIMIT = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_END   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_run_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // take no item while reset is held
                o_run_ready = i_rst_n;
                if (i_run_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_sts.len_zero ? S_END : S_LIMIT;
            end
            S_LIMIT: begin
                o_cmd.limit = 1'b1;
                n_state     = S_STEP;
            end
            S_STEP: begin
                // hold while the pending segment cannot move to the output
                if (!(i_sts.seg_vis && i_sts.pend_valid && !i_sts.out_free)) begin
                    o_cmd.step = 1'b1;
                    n_state    = i_sts.rem_zero ? S_END : S_LIMIT;
                end
            end
            S_END: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/rle_ovl_dp.sv -----
// Datapath: position, segment limits, pending segment and output register.
module rle_ovl_dp
    import rle_ovl_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_cfg                                i_cfg,
    input  logic [$clog2(MAX_LINE_WIDTH+1)-1:0] i_line_width,
    input  t_dp_cmd                             i_cmd,
    output t_dp_sts                             o_sts,
    input  logic [9:0]                          i_run_length,
    input  logic [3:0]                          i_color_index,
    input  logic                                i_first_run,
    output logic                                o_seg_valid,
    input  logic                                i_seg_ready,
    output t_seg                                o_seg,
    output logic                                o_last_segment
);
    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    localparam int LW_W  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int AW    = ((LW_W > 11) ? LW_W : 11) + 1;

    logic [COL_W-1:0] r_col;
    logic [9:0]       r_row;
    logic [9:0]       r_len;
    logic [3:0]       r_color;
    logic [AW-1:0]    r_limit;
    logic             r_clip;
    t_seg             r_pend;
    logic             r_pend_valid;
    t_seg             r_out;
    logic             r_out_last;
    logic             r_out_valid;

    logic [AW-1:0] col_e;
    logic [AW-1:0] lw_e;
    logic [AW-1:0] lim_line;
    logic [AW-1:0] d_left;
    logic [AW-1:0] d_right;
    logic          in_rows;
    logic [AW-1:0] n_limit;
    logic          n_clip;
    logic [AW-1:0] seg_w;
    logic [AW-1:0] col_sum;
    logic [9:0]    len_rem;
    logic          color_ok;
    logic          seg_vis;
    logic          out_free;
    logic          out_load;
    t_seg          new_seg;

    assign col_e = AW'(r_col);
    assign lw_e  = AW'(i_line_width);

    // Segment limit from the line end and the clip edges
    always_comb begin
        lim_line = lw_e - col_e;
        d_left   = AW'(i_cfg.win_left) - col_e;
        d_right  = AW'(i_cfg.win_right) - col_e + AW'(1);
        in_rows  = (r_row >= i_cfg.win_top) && (r_row <= i_cfg.win_bottom);
        n_limit  = lim_line;
        n_clip   = 1'b0;
        if (in_rows) begin
            if (col_e < AW'(i_cfg.win_left)) begin
                if (d_left < lim_line) begin
                    n_limit = d_left;
                end
            end else if (col_e <= AW'(i_cfg.win_right)) begin
                n_clip = 1'b1;
                if (d_right < lim_line) begin
                    n_limit = d_right;
                end
            end
        end
    end

    always_comb begin
        seg_w    = (AW'(r_len) < r_limit) ? AW'(r_len) : r_limit;
        col_sum  = col_e + seg_w;
        len_rem  = r_len - 10'(seg_w);
        color_ok = 32'(r_color) < PALETTE_ENTRIES;
        seg_vis  = color_ok && i_cfg.opaque_masks[{r_clip, r_color}];
        new_seg.x     = 11'(AW'(i_cfg.origin_x) + col_e);
        new_seg.y     = {1'b0, i_cfg.origin_y} + {1'b0, r_row};
        new_seg.width = 11'(seg_w);
        new_seg.color = r_color;
        new_seg.clip  = r_clip;
    end

    assign out_free = !r_out_valid || i_seg_ready;
    assign out_load = r_pend_valid && ((i_cmd.step && seg_vis) || i_cmd.flush);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len   <= i_run_length;
            r_color <= i_color_index;
        end else if (i_cmd.step) begin
            r_len <= len_rem;
        end
        if (i_cmd.limit) begin
            r_limit <= n_limit;
            r_clip  <= n_clip;
        end
        if (i_cmd.step && seg_vis) begin
            r_pend <= new_seg;
        end
        if (out_load) begin
            r_out      <= r_pend;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load && i_first_run) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_cmd.start && (r_len != 10'd0) && (col_e >= lw_e)) begin
                // wrap first when the width was lowered mid-image
                r_col <= '0;
                r_row <= r_row + 10'd1;
            end else if (i_cmd.step) begin
                if (col_sum == lw_e) begin
                    r_col <= '0;
                    r_row <= r_row + 10'd1;
                end else begin
                    r_col <= COL_W'(col_sum);
                end
            end
            if (i_cmd.step && seg_vis) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_seg_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.len_zero   = (r_len == 10'd0);
    assign o_sts.rem_zero   = (len_rem == 10'd0);
    assign o_sts.seg_vis    = seg_vis;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;

    assign o_seg_valid    = r_out_valid;
    assign o_seg          = r_out;
    assign o_last_segment = r_out_last;

endmodule

// ----- src/rle_overlay_span_splitter.sv -----
// Top level of the run-length overlay span splitter.
//
//   channel  direction  handshake                   payload
//   cfg      in         i_cfg_we                    i_cfg_index, i_cfg_data
//   run      in         i_run_valid / o_run_ready   run_length, color_index, first_run
//   seg      out        o_seg_valid / i_seg_ready   seg_x, seg_y, seg_width, seg_color,
//                                                   clip_pal_sel, last_segment
//
// A run is split by load and start, a limit and a step per segment, and an
// end step. Each visible segment waits in a one-deep buffer until the next
// one is known, so the run's last segment can be flagged.
// A stalled output holds the step sequencer; the next run is taken while the
// final segment still sits in the output register.
// Reset is synchronous, active low; it loads the register defaults and
// zeroes the column and row.
module rle_overlay_span_splitter
    import rle_ovl_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_run_valid,
    output logic        o_run_ready,
    input  logic [9:0]  i_run_length,
    input  logic [3:0]  i_color_index,
    input  logic        i_first_run,
    output logic        o_seg_valid,
    input  logic        i_seg_ready,
    output logic [10:0] o_seg_x,
    output logic [10:0] o_seg_y,
    output logic [10:0] o_seg_width,
    output logic [3:0]  o_seg_color,
    output logic        o_clip_pal_sel,
    output logic        o_last_segment
);
    localparam int LW_W = $clog2(MAX_LINE_WIDTH + 1);

    t_cfg            cfg;
    logic [LW_W-1:0] line_width;
    t_dp_cmd         cmd;
    t_dp_sts         sts;
    t_seg            seg;

    rle_ovl_cfg #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg        (cfg),
        .o_line_width (line_width)
    );

    rle_ovl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (i_run_valid),
        .o_run_ready (o_run_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rle_ovl_dp #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_line_width   (line_width),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_run_length   (i_run_length),
        .i_color_index  (i_color_index),
        .i_first_run    (i_first_run),
        .o_seg_valid    (o_seg_valid),
        .i_seg_ready    (i_seg_ready),
        .o_seg          (seg),
        .o_last_segment (o_last_segment)
    );

    assign o_seg_x        = seg.x;
    assign o_seg_y        = seg.y;
    assign o_seg_width    = seg.width;
    assign o_seg_color    = seg.color;
    assign o_clip_pal_sel = seg.clip;

endmodule

// ----- bench/span_check_pkg.sv -----
// Span predictor and scoreboard for the overlay run splitter bench.
`timescale 1ns / 1ps

package span_check_pkg;
    import rle_ovl_pkg::*;

    localparam int LINE_PX_MAX = 1024;
    localparam int SPANS_PER_RUN_MAX = 64;

    typedef struct packed {
        t_seg seg;
        logic last;
    } t_span;

    class span_tracker;
        t_cfg       cfg;
        logic [9:0] cur_col;
        logic [9:0] cur_row;
        t_span      pending_spans[$];
        int         mismatches;

        function new();
            cfg.overlay_width = OVERLAY_WIDTH_RST;
            cfg.win_left      = WIN_LEFT_RST;
            cfg.win_right     = WIN_RIGHT_RST;
            cfg.win_top       = WIN_TOP_RST;
            cfg.win_bottom    = WIN_BOTTOM_RST;
            cfg.origin_x      = ORIGIN_X_RST;
            cfg.origin_y      = ORIGIN_Y_RST;
            cfg.opaque_masks  = OPAQUE_MASKS_RST;
            cur_col = '0;
            cur_row = '0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_spans.size();
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_OVERLAY_WIDTH: cfg.overlay_width = data[10:0];
                REG_WIN_LEFT:      cfg.win_left = data[9:0];
                REG_WIN_RIGHT:     cfg.win_right = data[9:0];
                REG_WIN_TOP:       cfg.win_top = data[9:0];
                REG_WIN_BOTTOM:    cfg.win_bottom = data[9:0];
                REG_ORIGIN_X:      cfg.origin_x = data[9:0];
                REG_ORIGIN_Y:      cfg.origin_y = data[9:0];
                REG_OPAQUE_MASKS:  cfg.opaque_masks = data;
                default: ;
            endcase
        endfunction

        // Walk one run along the overlay lines and queue its visible spans.
        function void note_run(logic [9:0] run_len, logic [3:0] color, logic first);
            int unsigned left_px, line_w, col, row, span_max, span_w;
            logic        in_clip;
            logic [4:0]  mask_bit;
            t_span       run_spans[$];
            t_span       s;

            line_w = cfg.overlay_width;
            if (line_w < MIN_LINE_WIDTH) line_w = MIN_LINE_WIDTH;
            if (line_w > LINE_PX_MAX) line_w = LINE_PX_MAX;
            if (first) begin
                cur_col = '0;
                cur_row = '0;
            end
            col = cur_col;
            row = cur_row;
            left_px = run_len;
            while (left_px > 0) begin
                // width may have shrunk under the current column
                if (col >= line_w) begin
                    col = 0;
                    row = (row + 1) & 32'h3FF;
                end
                span_max = line_w - col;
                in_clip = 1'b0;
                if (row >= cfg.win_top && row <= cfg.win_bottom) begin
                    if (col < cfg.win_left) begin
                        if (cfg.win_left - col < span_max) span_max = cfg.win_left - col;
                    end else if (col <= cfg.win_right) begin
                        in_clip = 1'b1;
                        if (cfg.win_right - col + 1 < span_max)
                            span_max = cfg.win_right - col + 1;
                    end
                end
                span_w = (left_px < span_max) ? left_px : span_max;
                mask_bit = {in_clip, color};
                if (color < PALETTE_ENTRIES && cfg.opaque_masks[mask_bit] == 1'b1 &&
                    run_spans.size() < SPANS_PER_RUN_MAX) begin
                    s.seg.x = 11'(cfg.origin_x + col);
                    s.seg.y = 11'(cfg.origin_y + row);
                    s.seg.width = 11'(span_w);
                    s.seg.color = color;
                    s.seg.clip = in_clip;
                    s.last = 1'b0;
                    run_spans.push_back(s);
                end
                left_px -= span_w;
                col += span_w;
                if (col == line_w) begin
                    col = 0;
                    row = (row + 1) & 32'h3FF;
                end
            end
            cur_col = 10'(col);
            cur_row = 10'(row);
            if (run_spans.size() > 0) begin
                s = run_spans.pop_back();
                s.last = 1'b1;
                run_spans.push_back(s);
            end
            foreach (run_spans[i]) pending_spans.push_back(run_spans[i]);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_segment(logic [10:0] x, logic [10:0] y, logic [10:0] w,
                           logic [3:0] color, logic clip, logic last);
            t_span want;

            if (pending_spans.size() == 0) begin
                report_mismatch("segment with nothing queued, seg_x", x, 0);
                return;
            end
            want = pending_spans.pop_front();
            if (x !== want.seg.x) report_mismatch("seg_x", x, want.seg.x);
            if (y !== want.seg.y) report_mismatch("seg_y", y, want.seg.y);
            if (w !== want.seg.width) report_mismatch("seg_width", w, want.seg.width);
            if (color !== want.seg.color) report_mismatch("seg_color", color, want.seg.color);
            if (clip !== want.seg.clip) report_mismatch("clip_pal_sel", clip, want.seg.clip);
            if (last !== want.last) report_mismatch("last_segment", last, want.last);
        endtask
    endclass

endpackage

// ----- bench/tb_rle_overlay_span_splitter.sv -----
// Testbench top for the overlay run splitter: drives runs, checks segments.
`timescale 1ns / 1ps

module tb_rle_overlay_span_splitter;
    import rle_ovl_pkg::*;
    import span_check_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_run_valid = 1'b0;
    logic        o_run_ready;
    logic [9:0]  i_run_length = '0;
    logic [3:0]  i_color_index = '0;
    logic        i_first_run = 1'b0;
    logic        o_seg_valid;
    logic        i_seg_ready = 1'b0;
    logic [10:0] o_seg_x;
    logic [10:0] o_seg_y;
    logic [10:0] o_seg_width;
    logic [3:0]  o_seg_color;
    logic        o_clip_pal_sel;
    logic        o_last_segment;

    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    span_tracker tracker;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    rle_overlay_span_splitter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_run_valid    (i_run_valid),
        .o_run_ready    (o_run_ready),
        .i_run_length   (i_run_length),
        .i_color_index  (i_color_index),
        .i_first_run    (i_first_run),
        .o_seg_valid    (o_seg_valid),
        .i_seg_ready    (i_seg_ready),
        .o_seg_x        (o_seg_x),
        .o_seg_y        (o_seg_y),
        .o_seg_width    (o_seg_width),
        .o_seg_color    (o_seg_color),
        .o_clip_pal_sel (o_clip_pal_sel),
        .o_last_segment (o_last_segment)
    );

    function automatic t_cfg make_cfg(int w, int l, int r, int t, int b,
                                      int ox, int oy, logic [31:0] m);
        t_cfg c;

        c.overlay_width = 11'(w);
        c.win_left = 10'(l);
        c.win_right = 10'(r);
        c.win_top = 10'(t);
        c.win_bottom = 10'(b);
        c.origin_x = 10'(ox);
        c.origin_y = 10'(oy);
        c.opaque_masks = m;
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(REG_OVERLAY_WIDTH, {21'd0, c.overlay_width});
        write_reg(REG_WIN_LEFT, {22'd0, c.win_left});
        write_reg(REG_WIN_RIGHT, {22'd0, c.win_right});
        write_reg(REG_WIN_TOP, {22'd0, c.win_top});
        write_reg(REG_WIN_BOTTOM, {22'd0, c.win_bottom});
        write_reg(REG_ORIGIN_X, {22'd0, c.origin_x});
        write_reg(REG_ORIGIN_Y, {22'd0, c.origin_y});
        write_reg(REG_OPAQUE_MASKS, c.opaque_masks);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Hold valid high from one item to the next unless a gap is drawn.
    task automatic send_run(input logic [9:0] len, input logic [3:0] color,
                            input logic first);
        int gap;

        gap = tx_burst ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_run_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_run_valid = 1'b1;
        i_run_length = len;
        i_color_index = color;
        i_first_run = first;
        @(posedge i_clk);
        while (o_run_ready !== 1'b1) @(posedge i_clk);
        tracker.note_run(len, color, first);
    endtask

    // Drop valid, wait out every queued segment, then let a silent run finish.
    task automatic settle();
        @(negedge i_clk);
        i_run_valid = 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : seg_sink
        int stall;

        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            @(negedge i_clk);
            if (stall > 0) begin
                i_seg_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_seg_ready = 1'b1;
            @(posedge i_clk);
            while (o_seg_valid !== 1'b1) @(posedge i_clk);
            tracker.check_segment(o_seg_x, o_seg_y, o_seg_width, o_seg_color,
                                  o_clip_pal_sel, o_last_segment);
        end
    end

    initial begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_run_valid && o_run_ready) || (o_seg_valid && i_seg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int pick, len, w, l, r, t, b, tmp;
        logic [31:0] m;

        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset palette is all transparent: nothing comes out
        send_run(10'd1023, 4'd15, 1'b1);
        send_run(10'd0, 4'd0, 1'b0);
        send_run(10'd37, 4'd9, 1'b0);
        settle();

        // width below minimum, whole overlay in the clip window, origin at max
        load_config(make_cfg(0, 0, 1023, 0, 1023, 1023, 1023, 32'hFFFF_FFFF));
        send_run(10'd1023, 4'd15, 1'b1);
        send_run(10'd1, 4'd0, 1'b0);
        send_run(10'd0, 4'd7, 1'b0);
        send_run(10'd64, 4'd5, 1'b0);
        send_run(10'd10, 4'd1, 1'b1);
        send_run(10'd0, 4'd8, 1'b1);
        settle();

        // width above maximum, narrow clip window, mixed palette masks
        load_config(make_cfg(2047, 100, 200, 0, 3, 0, 0, 32'hFFFF_00FF));
        send_run(10'd1023, 4'd3, 1'b1);
        send_run(10'd900, 4'd12, 1'b0);
        send_run(10'd700, 4'd2, 1'b1);
        send_run(10'd50, 4'd4, 1'b0);
        settle();

        // shrink the width under the current column; empty clip window
        load_config(make_cfg(100, 50, 40, 9, 2, 5, 7, 32'h0000_FFFF));
        send_run(10'd30, 4'd6, 1'b0);
        send_run(10'd500, 4'd15, 1'b0);
        settle();

        // walk past row 1023 with mostly transparent runs
        load_config(make_cfg(64, 0, 1023, 0, 1023, $urandom_range(0, 1023),
                             $urandom_range(0, 1023), 32'h0020_0020));
        for (int n = 0; n < 70; n++) begin
            if (n % 16 == 0) tx_burst = ($urandom_range(0, 1) == 0);
            send_run(10'd1023, (n % 8 == 7 || n >= 64) ? 4'd5 : 4'($urandom_range(0, 4)),
                     n == 0);
        end
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) w = $urandom_range(64, 200);
            else if (pick < 8) w = $urandom_range(201, 1024);
            else w = $urandom_range(0, 2047);
            if ($urandom_range(0, 4) == 0) begin
                l = $urandom_range(0, 1023);
                r = $urandom_range(0, 1023);
                t = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end else begin
                l = $urandom_range(0, 300);
                r = l + $urandom_range(0, 400);
                t = $urandom_range(0, 40);
                b = t + $urandom_range(0, 60);
                if ($urandom_range(0, 5) == 0) begin
                    tmp = l;
                    l = r + 1;
                    r = tmp;
                end
                if ($urandom_range(0, 5) == 0) begin
                    tmp = t;
                    t = b + 1;
                    b = tmp;
                end
            end
            m = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom();
            load_config(make_cfg(w, l, r, t, b, $urandom_range(0, 1023),
                                 $urandom_range(0, 1023), m));
            for (int n = 0; n < 64; n++) begin
                if (n % 16 == 0) begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 3) len = 0;
                else if (pick < 6) len = 1023;
                else if (pick < 70) len = $urandom_range(1, 80);
                else len = $urandom_range(81, 1023);
                send_run(10'(len), 4'($urandom_range(0, 15)), $urandom_range(0, 19) == 0);
            end
            settle();
        end

        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
